// File: rtl/lce_pkg.sv
// ----------------------------------------------------------------------------
// LED color engine package
// Shared constants, codes, state types and the multiply-divide unit's
// request and status words.
// ----------------------------------------------------------------------------
`default_nettype none

package lce_pkg;

    // Data widths
    localparam int DATA_W = 8;
    localparam int PROD_W = 2 * DATA_W;
    localparam int CNT_W  = $clog2(PROD_W);

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(DATA_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

    // Hue cycling divider
    localparam int CYCLE_DIVIDE = 4;
    localparam int PHASE_W      = (CYCLE_DIVIDE > 1) ? $clog2(CYCLE_DIVIDE) : 1;

    typedef logic [PHASE_W-1:0] t_phase;
    typedef logic [PHASE_W:0]   t_phase_ext;

    localparam t_phase_ext PHASE_MOD = (PHASE_W + 1)'(CYCLE_DIVIDE);

    // Color constants
    localparam logic [DATA_W-1:0] HUE_STEP       = 8'd43;
    localparam logic [DATA_W-1:0] HUE_GREEN_BASE = 8'd86;
    localparam logic [DATA_W-1:0] HUE_BLUE_BASE  = 8'd172;
    localparam logic [DATA_W-1:0] FULL_SCALE     = 8'd255;

    // Operation codes
    localparam logic [1:0] FN_TIMER   = 2'd0;
    localparam logic [1:0] FN_SET_RGB = 2'd1;
    localparam logic [1:0] FN_SET_HSV = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_LIGHT_MODE = 2'd0;
    localparam logic [1:0] CFG_RGB_MODE   = 2'd1;
    localparam logic [1:0] CFG_LAMP_INT   = 2'd2;
    localparam logic [1:0] CFG_DIM_INT    = 2'd3;

    // light_mode bits
    localparam int LM_LAMP_BIT = 0;
    localparam int LM_RGB_BIT  = 1;

    // rgb_mode codes
    localparam logic [1:0] RGBM_DIMMED = 2'd1;
    localparam logic [1:0] RGBM_CYCLE  = 2'd2;

    // Multiply-divide unit states
    typedef enum logic [1:0] {
        MDV_IDLE,
        MDV_MUL,
        MDV_DIV
    } t_mdv_state;

    // Sequencer states
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_PLAN,
        SEQ_HUE,
        SEQ_SAT,
        SEQ_CVAL,
        SEQ_XVAL,
        SEQ_SCL_RED,
        SEQ_SCL_GREEN,
        SEQ_SCL_BLUE,
        SEQ_DONE
    } t_seq_state;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] mcand;
        logic [DATA_W-1:0] mplier;
        logic [DATA_W-1:0] divisor;
    } t_mdv_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quo;
    } t_mdv_stat;

    // Hue sector 0..5
    function automatic logic [2:0] f_hue_sector(input logic [DATA_W-1:0] h);
        logic [2:0] sec;
        priority if (h < 8'd43)  sec = 3'd0;
        else if     (h < 8'd86)  sec = 3'd1;
        else if     (h < 8'd129) sec = 3'd2;
        else if     (h < 8'd172) sec = 3'd3;
        else if     (h < 8'd215) sec = 3'd4;
        else                     sec = 3'd5;
        return sec;
    endfunction

    // First hue of a sector
    function automatic logic [DATA_W-1:0] f_sector_base(input logic [2:0] sec);
        logic [DATA_W-1:0] base;
        unique case (sec)
            3'd0:    base = 8'd0;
            3'd1:    base = 8'd43;
            3'd2:    base = 8'd86;
            3'd3:    base = 8'd129;
            3'd4:    base = 8'd172;
            default: base = 8'd215;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

// File: rtl/lce_muldiv.sv
// ----------------------------------------------------------------------------
// LED color engine bit-serial multiply-divide unit
// Computes (mcand * mplier) / divisor: shift-add multiply one bit per cycle,
// then restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lce_muldiv (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire lce_pkg::t_mdv_req  i_req,
    output lce_pkg::t_mdv_stat      o_stat
);

    lce_pkg::t_mdv_state r_state, n_state;
    logic [lce_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [lce_pkg::PROD_W-1:0] r_acc, n_acc;
    logic [lce_pkg::PROD_W-1:0] r_mcand, n_mcand;
    logic [lce_pkg::DATA_W-1:0] r_mplier, n_mplier;
    logic [lce_pkg::DATA_W-1:0] r_div, n_div;
    logic [lce_pkg::DATA_W-1:0] r_rem, n_rem;
    logic                       r_done, n_done;

    logic [lce_pkg::DATA_W:0] w_trial;
    logic [lce_pkg::DATA_W:0] w_diff;
    logic                     w_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lce_pkg::MDV_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_div    <= n_div;
        r_rem    <= n_rem;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_div    = r_div;
        n_rem    = r_rem;
        n_done   = 1'b0;
        w_trial  = {r_rem, r_acc[lce_pkg::PROD_W-1]};
        w_ge     = (w_trial >= {1'b0, r_div});
        w_diff   = w_trial - {1'b0, r_div};
        unique case (r_state)
            lce_pkg::MDV_IDLE: begin
                if (i_req.start) begin
                    n_acc    = '0;
                    n_mcand  = {{lce_pkg::DATA_W{1'b0}}, i_req.mcand};
                    n_mplier = i_req.mplier;
                    n_div    = i_req.divisor;
                    n_cnt    = '0;
                    n_state  = lce_pkg::MDV_MUL;
                end
            end
            lce_pkg::MDV_MUL: begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = {r_mcand[lce_pkg::PROD_W-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[lce_pkg::DATA_W-1:1]};
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == lce_pkg::MUL_LAST) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_state = lce_pkg::MDV_DIV;
                end
            end
            lce_pkg::MDV_DIV: begin
                n_rem = w_ge ? w_diff[lce_pkg::DATA_W-1:0] : w_trial[lce_pkg::DATA_W-1:0];
                n_acc = {r_acc[lce_pkg::PROD_W-2:0], w_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == lce_pkg::DIV_LAST) begin
                    n_cnt   = '0;
                    n_done  = 1'b1;
                    n_state = lce_pkg::MDV_IDLE;
                end
            end
            default: begin
                n_state = lce_pkg::MDV_IDLE;
            end
        endcase
    end

    assign o_stat.done = r_done;
    assign o_stat.quo  = r_acc[lce_pkg::DATA_W-1:0];

endmodule

`default_nettype wire

// File: rtl/led_color_engine_hsv.sv
// ----------------------------------------------------------------------------
// LED color engine with HSV/RGB conversion
// Timer wrap detection, hue cycling, RGB/HSV conversion and level scaling.
// ----------------------------------------------------------------------------
// One word at a time: the input is taken only while the sequencer is idle,
// and a finished result sits in the output register while the next word is
// worked on. All products and quotients run through one bit-serial
// multiply-divide unit, each operation stepping through 8 multiply bits and
// then 16 quotient bits. A timer sample that does not step the hue runs
// three scaling operations; a color write, or a timer sample that steps the
// hue, runs two conversion operations plus three scaling operations. An RGB
// write whose channels are all equal skips the conversion. The input is free
// again in the same cycle as the result appears, so no new word is taken
// before the last one is through. A finished word also waits in the done
// state while the previous result is still held by the output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module led_color_engine_hsv (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // configuration
    input  wire        i_cfg_we,
    input  wire  [1:0] i_cfg_idx,
    input  wire  [7:0] i_cfg_data,
    // input words
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire  [1:0] i_func,
    input  wire  [7:0] i_counter_sample,
    input  wire  [7:0] i_chan_a,
    input  wire  [7:0] i_chan_b,
    input  wire  [7:0] i_chan_c,
    // result words
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [7:0] o_lamp_level,
    output logic [7:0] o_red_level,
    output logic [7:0] o_green_level,
    output logic [7:0] o_blue_level,
    output logic       o_timer_wrapped,
    output logic [7:0] o_hue_now
);

    // configuration
    logic [1:0] r_light_mode;
    logic [1:0] r_rgb_mode;
    logic [7:0] r_lamp_int;
    logic [7:0] r_dim_int;

    // sequencer
    lce_pkg::t_seq_state r_state, n_state;
    logic r_issued, n_issued;
    logic r_derive_hsv, n_derive_hsv;
    logic r_derive_rgb, n_derive_rgb;
    logic r_wrapped, n_wrapped;

    // color state
    logic [7:0]      r_prev, n_prev;
    lce_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_hue, n_hue;
    logic [7:0] r_sat, n_sat;
    logic [7:0] r_val, n_val;
    logic [7:0] r_red, n_red;
    logic [7:0] r_green, n_green;
    logic [7:0] r_blue, n_blue;
    logic [7:0] r_cval, n_cval;
    logic [7:0] r_lvl_red, n_lvl_red;
    logic [7:0] r_lvl_green, n_lvl_green;
    logic [7:0] r_lvl_blue, n_lvl_blue;

    // output register
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_lamp, n_out_lamp;
    logic [7:0] r_out_red, n_out_red;
    logic [7:0] r_out_green, n_out_green;
    logic [7:0] r_out_blue, n_out_blue;
    logic       r_out_wrapped, n_out_wrapped;
    logic [7:0] r_out_hue, n_out_hue;

    lce_pkg::t_mdv_req  w_req;
    lce_pkg::t_mdv_stat w_stat;

    logic                w_accept;
    logic                w_load;
    logic                w_wrap;
    lce_pkg::t_phase_ext w_phase_inc;
    lce_pkg::t_phase     w_phase_next;
    logic [7:0] w_mx;
    logic [7:0] w_mn;
    logic [7:0] w_delta;
    logic [7:0] w_hue_num;
    logic       w_hue_neg;
    logic [7:0] w_hue_base;
    logic [2:0] w_sector;
    logic [7:0] w_frac;
    logic [7:0] w_xfrac;
    logic [7:0] w_m;
    logic       w_dimmed;
    logic [7:0] w_scale;

    lce_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_stat  (w_stat)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_mode <= 2'd0;
            r_rgb_mode   <= 2'd0;
            r_lamp_int   <= 8'd255;
            r_dim_int    <= 8'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lce_pkg::CFG_LIGHT_MODE: r_light_mode <= i_cfg_data[1:0];
                lce_pkg::CFG_RGB_MODE:   r_rgb_mode   <= i_cfg_data[1:0];
                lce_pkg::CFG_LAMP_INT:   r_lamp_int   <= i_cfg_data;
                lce_pkg::CFG_DIM_INT:    r_dim_int    <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lce_pkg::SEQ_IDLE;
            r_issued     <= 1'b0;
            r_derive_hsv <= 1'b0;
            r_derive_rgb <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev       <= '0;
            r_phase      <= '0;
            r_hue        <= '0;
            r_sat        <= '0;
            r_val        <= '0;
            r_red        <= '0;
            r_green      <= '0;
            r_blue       <= '0;
        end else begin
            r_state      <= n_state;
            r_issued     <= n_issued;
            r_derive_hsv <= n_derive_hsv;
            r_derive_rgb <= n_derive_rgb;
            r_out_valid  <= n_out_valid;
            r_prev       <= n_prev;
            r_phase      <= n_phase;
            r_hue        <= n_hue;
            r_sat        <= n_sat;
            r_val        <= n_val;
            r_red        <= n_red;
            r_green      <= n_green;
            r_blue       <= n_blue;
        end
        r_wrapped     <= n_wrapped;
        r_cval        <= n_cval;
        r_lvl_red     <= n_lvl_red;
        r_lvl_green   <= n_lvl_green;
        r_lvl_blue    <= n_lvl_blue;
        r_out_lamp    <= n_out_lamp;
        r_out_red     <= n_out_red;
        r_out_green   <= n_out_green;
        r_out_blue    <= n_out_blue;
        r_out_wrapped <= n_out_wrapped;
        r_out_hue     <= n_out_hue;
    end

    // narrow datapath helpers
    always_comb begin
        w_accept     = i_in_valid && (r_state == lce_pkg::SEQ_IDLE);
        w_load       = (r_state == lce_pkg::SEQ_DONE) && (!r_out_valid || !i_out_stall);
        w_wrap       = (i_counter_sample < r_prev);
        w_phase_inc  = {1'b0, r_phase} + 1'b1;
        w_phase_next = (w_phase_inc == lce_pkg::PHASE_MOD) ?
                       '0 : w_phase_inc[lce_pkg::PHASE_W-1:0];

        w_mx = r_red;
        if (r_green > w_mx) w_mx = r_green;
        if (r_blue > w_mx)  w_mx = r_blue;
        w_mn = r_red;
        if (r_green < w_mn) w_mn = r_green;
        if (r_blue < w_mn)  w_mn = r_blue;
        w_delta = w_mx - w_mn;

        priority if (w_mx == r_red) begin
            w_hue_base = 8'd0;
            w_hue_neg  = (r_green < r_blue);
            w_hue_num  = w_hue_neg ? (r_blue - r_green) : (r_green - r_blue);
        end else if (w_mx == r_green) begin
            w_hue_base = lce_pkg::HUE_GREEN_BASE;
            w_hue_neg  = (r_blue < r_red);
            w_hue_num  = w_hue_neg ? (r_red - r_blue) : (r_blue - r_red);
        end else begin
            w_hue_base = lce_pkg::HUE_BLUE_BASE;
            w_hue_neg  = (r_red < r_green);
            w_hue_num  = w_hue_neg ? (r_green - r_red) : (r_red - r_green);
        end

        w_sector = lce_pkg::f_hue_sector(r_hue);
        w_frac   = r_hue - lce_pkg::f_sector_base(w_sector);
        w_xfrac  = w_sector[0] ? (lce_pkg::HUE_STEP - w_frac) : w_frac;
        w_m      = r_val - r_cval;

        w_dimmed = (r_rgb_mode == lce_pkg::RGBM_DIMMED);
        w_scale  = w_dimmed ? r_dim_int : lce_pkg::FULL_SCALE;
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_issued      = r_issued;
        n_derive_hsv  = r_derive_hsv;
        n_derive_rgb  = r_derive_rgb;
        n_wrapped     = r_wrapped;
        n_prev        = r_prev;
        n_phase       = r_phase;
        n_hue         = r_hue;
        n_sat         = r_sat;
        n_val         = r_val;
        n_red         = r_red;
        n_green       = r_green;
        n_blue        = r_blue;
        n_cval        = r_cval;
        n_lvl_red     = r_lvl_red;
        n_lvl_green   = r_lvl_green;
        n_lvl_blue    = r_lvl_blue;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_lamp    = r_out_lamp;
        n_out_red     = r_out_red;
        n_out_green   = r_out_green;
        n_out_blue    = r_out_blue;
        n_out_wrapped = r_out_wrapped;
        n_out_hue     = r_out_hue;

        w_req.start   = 1'b0;
        w_req.mcand   = '0;
        w_req.mplier  = '0;
        w_req.divisor = '0;

        unique case (r_state)
            lce_pkg::SEQ_IDLE: begin
                if (w_accept) begin
                    n_derive_hsv = 1'b0;
                    n_derive_rgb = 1'b0;
                    n_wrapped    = 1'b0;
                    n_state      = lce_pkg::SEQ_PLAN;
                    unique case (i_func)
                        lce_pkg::FN_TIMER: begin
                            n_wrapped = w_wrap;
                            n_prev    = i_counter_sample;
                            if (w_wrap) begin
                                n_phase = w_phase_next;
                                if (w_phase_next == '0 && r_rgb_mode == lce_pkg::RGBM_CYCLE) begin
                                    n_hue        = r_hue + 1'b1;
                                    n_derive_rgb = 1'b1;
                                end
                            end
                        end
                        lce_pkg::FN_SET_RGB: begin
                            n_red        = i_chan_a;
                            n_green      = i_chan_b;
                            n_blue       = i_chan_c;
                            n_derive_hsv = 1'b1;
                        end
                        lce_pkg::FN_SET_HSV: begin
                            n_hue        = i_chan_a;
                            n_sat        = i_chan_b;
                            n_val        = i_chan_c;
                            n_derive_rgb = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lce_pkg::SEQ_PLAN: begin
                priority if (r_derive_hsv) begin
                    n_val = w_mx;
                    if (w_delta == '0) begin
                        n_hue   = '0;
                        n_sat   = '0;
                        n_state = lce_pkg::SEQ_SCL_RED;
                    end else begin
                        n_state = lce_pkg::SEQ_HUE;
                    end
                end else if (r_derive_rgb) begin
                    n_state = lce_pkg::SEQ_CVAL;
                end else begin
                    n_state = lce_pkg::SEQ_SCL_RED;
                end
            end
            lce_pkg::SEQ_HUE: begin
                w_req.mcand   = w_hue_num;
                w_req.mplier  = lce_pkg::HUE_STEP;
                w_req.divisor = w_delta;
                if (w_stat.done) begin
                    n_hue   = w_hue_neg ? (w_hue_base - w_stat.quo) : (w_hue_base + w_stat.quo);
                    n_state = lce_pkg::SEQ_SAT;
                end
            end
            lce_pkg::SEQ_SAT: begin
                w_req.mcand   = w_delta;
                w_req.mplier  = lce_pkg::FULL_SCALE;
                w_req.divisor = w_mx;
                if (w_stat.done) begin
                    n_sat   = w_stat.quo;
                    n_state = lce_pkg::SEQ_SCL_RED;
                end
            end
            lce_pkg::SEQ_CVAL: begin
                w_req.mcand   = r_sat;
                w_req.mplier  = r_val;
                w_req.divisor = lce_pkg::FULL_SCALE;
                if (w_stat.done) begin
                    n_cval  = w_stat.quo;
                    n_state = lce_pkg::SEQ_XVAL;
                end
            end
            lce_pkg::SEQ_XVAL: begin
                w_req.mcand   = r_cval;
                w_req.mplier  = w_xfrac;
                w_req.divisor = lce_pkg::HUE_STEP;
                if (w_stat.done) begin
                    unique case (w_sector)
                        3'd0: begin
                            n_red = r_cval + w_m; n_green = w_stat.quo + w_m; n_blue = w_m;
                        end
                        3'd1: begin
                            n_red = w_stat.quo + w_m; n_green = r_cval + w_m; n_blue = w_m;
                        end
                        3'd2: begin
                            n_red = w_m; n_green = r_cval + w_m; n_blue = w_stat.quo + w_m;
                        end
                        3'd3: begin
                            n_red = w_m; n_green = w_stat.quo + w_m; n_blue = r_cval + w_m;
                        end
                        3'd4: begin
                            n_red = w_stat.quo + w_m; n_green = w_m; n_blue = r_cval + w_m;
                        end
                        default: begin
                            n_red = r_cval + w_m; n_green = w_m; n_blue = w_stat.quo + w_m;
                        end
                    endcase
                    n_state = lce_pkg::SEQ_SCL_RED;
                end
            end
            lce_pkg::SEQ_SCL_RED: begin
                w_req.mcand   = r_red;
                w_req.mplier  = w_scale;
                w_req.divisor = lce_pkg::FULL_SCALE;
                if (w_stat.done) begin
                    n_lvl_red = w_stat.quo;
                    n_state   = lce_pkg::SEQ_SCL_GREEN;
                end
            end
            lce_pkg::SEQ_SCL_GREEN: begin
                w_req.mcand   = r_green;
                w_req.mplier  = w_scale;
                w_req.divisor = lce_pkg::FULL_SCALE;
                if (w_stat.done) begin
                    n_lvl_green = w_stat.quo;
                    n_state     = lce_pkg::SEQ_SCL_BLUE;
                end
            end
            lce_pkg::SEQ_SCL_BLUE: begin
                w_req.mcand   = r_blue;
                w_req.mplier  = w_scale;
                w_req.divisor = lce_pkg::FULL_SCALE;
                if (w_stat.done) begin
                    n_lvl_blue = w_stat.quo;
                    n_state    = lce_pkg::SEQ_DONE;
                end
            end
            lce_pkg::SEQ_DONE: begin
                if (w_load) begin
                    n_out_valid   = 1'b1;
                    n_out_lamp    = r_light_mode[lce_pkg::LM_LAMP_BIT] ?
                                    (w_dimmed ? r_dim_int : r_lamp_int) : 8'd0;
                    n_out_red     = r_light_mode[lce_pkg::LM_RGB_BIT] ? r_lvl_red : 8'd0;
                    n_out_green   = r_light_mode[lce_pkg::LM_RGB_BIT] ? r_lvl_green : 8'd0;
                    n_out_blue    = r_light_mode[lce_pkg::LM_RGB_BIT] ? r_lvl_blue : 8'd0;
                    n_out_wrapped = r_wrapped;
                    n_out_hue     = r_hue;
                    n_state       = lce_pkg::SEQ_IDLE;
                end
            end
            default: begin
                n_state = lce_pkg::SEQ_IDLE;
            end
        endcase

        // issue one unit operation per arithmetic state, drop the flag on its result
        w_req.start = (r_state == lce_pkg::SEQ_HUE      || r_state == lce_pkg::SEQ_SAT     ||
                       r_state == lce_pkg::SEQ_CVAL     || r_state == lce_pkg::SEQ_XVAL    ||
                       r_state == lce_pkg::SEQ_SCL_RED  || r_state == lce_pkg::SEQ_SCL_GREEN ||
                       r_state == lce_pkg::SEQ_SCL_BLUE) && !r_issued;
        if (w_req.start) begin
            n_issued = 1'b1;
        end else if (w_stat.done) begin
            n_issued = 1'b0;
        end
    end

    assign o_in_stall      = (r_state != lce_pkg::SEQ_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_lamp_level    = r_out_lamp;
    assign o_red_level     = r_out_red;
    assign o_green_level   = r_out_green;
    assign o_blue_level    = r_out_blue;
    assign o_timer_wrapped = r_out_wrapped;
    assign o_hue_now       = r_out_hue;

    a_accept_plans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == lce_pkg::SEQ_PLAN))
        else $error("accepted word did not enter planning");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == lce_pkg::SEQ_DONE))
        else $error("result raised outside the done state");

    a_unit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (r_issued && !w_req.start))
        else $error("unit result without a pending operation");

    a_hsv_value_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lce_pkg::SEQ_DONE && r_derive_hsv) |->
        (r_red <= r_val && r_green <= r_val && r_blue <= r_val))
        else $error("derived value is not the channel maximum");

endmodule

`default_nettype wire

// File: test/led_color_engine_hsv_tb.sv
// ----------------------------------------------------------------------------
// LED color engine testbench
// Checks each result word against its typed levels, if any, else against an
// in-bench model of the timer wrap counter, hue cycling, RGB/HSV conversion
// and level scaling. A short directed plan runs first, then randomized words
// under several idle and stall patterns and register settings, with a long output hold-off.
// ----------------------------------------------------------------------------
module led_color_engine_hsv_tb;

    import lce_pkg::*;

    localparam logic [1:0] FN_UNUSED   = 2'd3;
    localparam int         HOLD_CYCLES = 400;
    localparam int         CHUNKS      = 24;
    localparam int         CHUNK_WORDS = 50;
    localparam int         TAIL_CYCLES = 200;
    localparam int         MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] sample;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } word_t;

    typedef struct packed {
        logic [1:0] light;
        logic [1:0] rgb;
        logic [7:0] lamp;
        logic [7:0] dim;
    } cfg_t;

    typedef struct packed {
        logic [7:0] lamp;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       wrapped;
        logic [7:0] hue;
    } levels_t;

    typedef struct packed {
        bit      is_cfg;
        bit      has_exp;
        word_t   w;
        cfg_t    c;
        levels_t e;
    } row_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [7:0] i_cfg_data = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [1:0] i_func = '0;
    logic [7:0] i_counter_sample = '0;
    logic [7:0] i_chan_a = '0;
    logic [7:0] i_chan_b = '0;
    logic [7:0] i_chan_c = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_lamp_level;
    logic [7:0] o_red_level;
    logic [7:0] o_green_level;
    logic [7:0] o_blue_level;
    logic       o_timer_wrapped;
    logic [7:0] o_hue_now;

    // model state
    logic [7:0] prev_sample = '0;
    int         wrap_count = 0;
    logic [7:0] hue_q = '0;
    logic [7:0] sat_q = '0;
    logic [7:0] val_q = '0;
    logic [7:0] red_q = '0;
    logic [7:0] grn_q = '0;
    logic [7:0] blu_q = '0;
    logic [1:0] light_mode_q = 2'd0;
    logic [1:0] rgb_mode_q = 2'd0;
    logic [7:0] lamp_int_q = 8'd255;
    logic [7:0] dim_int_q = 8'd64;

    levels_t    pending_levels[$];
    row_t       plan_q[$];
    bit         typed_on = 1'b0;
    levels_t    typed_lv = '0;
    int         fail_cnt = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         hold_req = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    logic [7:0] timer_run = '0;

    led_color_engine_hsv DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_counter_sample (i_counter_sample),
        .i_chan_a         (i_chan_a),
        .i_chan_b         (i_chan_b),
        .i_chan_c         (i_chan_c),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_lamp_level     (o_lamp_level),
        .o_red_level      (o_red_level),
        .o_green_level    (o_green_level),
        .o_blue_level     (o_blue_level),
        .o_timer_wrapped  (o_timer_wrapped),
        .o_hue_now        (o_hue_now)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    function automatic int hue_term(input int num, input int den);
        if (num < 0) begin
            return -((43 * (-num)) / den);
        end
        return (43 * num) / den;
    endfunction

    function automatic void rgb_to_hsv();
        int r, g, b, mx, mn, d, h;
        r = red_q;
        g = grn_q;
        b = blu_q;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (d == 0) begin
            h = 0;
        end else if (mx == r) begin
            h = hue_term(g - b, d);
        end else if (mx == g) begin
            h = 86 + hue_term(b - r, d);
        end else begin
            h = 172 + hue_term(r - g, d);
        end
        hue_q = 8'((h + 256) & 255);
        sat_q = (mx == 0) ? 8'd0 : 8'((d * 255) / mx);
        val_q = 8'(mx);
    endfunction

    function automatic void hsv_to_rgb();
        int h, s, v, c, sector, f, x, m, r, g, b;
        h = hue_q;
        s = sat_q;
        v = val_q;
        c = (s * v) / 255;
        sector = h / 43;
        f = h - 43 * sector;
        x = (sector % 2 == 1) ? (c * (43 - f)) / 43 : (c * f) / 43;
        m = v - c;
        case (sector)
            0: begin r = c; g = x; b = 0; end
            1: begin r = x; g = c; b = 0; end
            2: begin r = 0; g = c; b = x; end
            3: begin r = 0; g = x; b = c; end
            4: begin r = x; g = 0; b = c; end
            default: begin r = c; g = 0; b = x; end
        endcase
        red_q = 8'(r + m);
        grn_q = 8'(g + m);
        blu_q = 8'(b + m);
    endfunction

    function automatic levels_t predict_levels(input word_t w);
        levels_t res;
        logic    wrapped;
        bit      dimmed;
        int      scale;
        wrapped = 1'b0;
        case (w.func)
            FN_TIMER: begin
                wrapped = (w.sample < prev_sample);
                prev_sample = w.sample;
                if (wrapped) begin
                    wrap_count = (wrap_count + 1) % CYCLE_DIVIDE;
                    if (wrap_count == 0 && rgb_mode_q == RGBM_CYCLE) begin
                        hue_q = hue_q + 8'd1;
                        hsv_to_rgb();
                    end
                end
            end
            FN_SET_RGB: begin
                red_q = w.a;
                grn_q = w.b;
                blu_q = w.c;
                rgb_to_hsv();
            end
            FN_SET_HSV: begin
                hue_q = w.a;
                sat_q = w.b;
                val_q = w.c;
                hsv_to_rgb();
            end
            default: ;
        endcase
        dimmed = (rgb_mode_q == RGBM_DIMMED);
        res.lamp = light_mode_q[LM_LAMP_BIT] ? (dimmed ? dim_int_q : lamp_int_q) : 8'd0;
        scale = dimmed ? int'(dim_int_q) : int'(FULL_SCALE);
        if (light_mode_q[LM_RGB_BIT]) begin
            res.red   = 8'((int'(red_q) * scale) / 255);
            res.green = 8'((int'(grn_q) * scale) / 255);
            res.blue  = 8'((int'(blu_q) * scale) / 255);
        end else begin
            res.red   = 8'd0;
            res.green = 8'd0;
            res.blue  = 8'd0;
        end
        res.wrapped = wrapped;
        res.hue = hue_q;
        return res;
    endfunction

    function automatic logic [7:0] pick_level();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.light = $urandom_range(1) ? 2'd3 : 2'($urandom_range(3));
        c.rgb   = 2'($urandom_range(3));
        c.lamp  = pick_level();
        c.dim   = pick_level();
        return c;
    endfunction

    function automatic word_t random_word();
        word_t w;
        int    pick;
        w.sample = 8'($urandom);
        w.a = 8'($urandom);
        w.b = 8'($urandom);
        w.c = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 50) begin
            w.func = FN_TIMER;
            if ($urandom_range(9) != 0) begin
                timer_run = timer_run + 8'($urandom_range(20, 160));
                w.sample = timer_run;
            end
        end else if (pick < 72) begin
            w.func = FN_SET_RGB;
            if ($urandom_range(7) == 0) begin
                w.b = w.a;
                w.c = w.a;
            end
        end else if (pick < 95) begin
            w.func = FN_SET_HSV;
            if ($urandom_range(3) == 0) begin
                w.a = 8'(43 * $urandom_range(1, 5) - 1 + $urandom_range(0, 2));
            end
        end else begin
            w.func = FN_UNUSED;
        end
        return w;
    endfunction

    task automatic add_word(input logic [1:0] f, input logic [7:0] s, input logic [7:0] a,
                            input logic [7:0] b, input logic [7:0] c);
        row_t r;
        r = '0;
        r.w = '{func: f, sample: s, a: a, b: b, c: c};
        plan_q.push_back(r);
    endtask

    task automatic add_checked(input logic [1:0] f, input logic [7:0] s, input logic [7:0] a,
                               input logic [7:0] b, input logic [7:0] c, input levels_t e);
        row_t r;
        r = '0;
        r.w = '{func: f, sample: s, a: a, b: b, c: c};
        r.has_exp = 1'b1;
        r.e = e;
        plan_q.push_back(r);
    endtask

    task automatic add_config(input logic [1:0] lm, input logic [1:0] rm,
                              input logic [7:0] li, input logic [7:0] di);
        row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.c = '{light: lm, rgb: rm, lamp: li, dim: di};
        plan_q.push_back(r);
    endtask

    task automatic offer_word(input word_t w, input bit has_typed, input levels_t lv);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid       <= 1'b1;
        i_func           <= w.func;
        i_counter_sample <= w.sample;
        i_chan_a         <= w.a;
        i_chan_b         <= w.b;
        i_chan_c         <= w.c;
        typed_on         <= has_typed;
        typed_lv         <= lv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_levels.size() != 0) @(posedge i_clk);
    endtask

    task automatic apply_config(input cfg_t c);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LIGHT_MODE;
        i_cfg_data <= {6'd0, c.light};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RGB_MODE;
        i_cfg_data <= {6'd0, c.rgb};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LAMP_INT;
        i_cfg_data <= c.lamp;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DIM_INT;
        i_cfg_data <= c.dim;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : p_check
        word_t   w;
        levels_t got;
        levels_t want;
        levels_t pred;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LIGHT_MODE: light_mode_q = i_cfg_data[1:0];
                    CFG_RGB_MODE:   rgb_mode_q = i_cfg_data[1:0];
                    CFG_LAMP_INT:   lamp_int_q = i_cfg_data;
                    default:        dim_int_q = i_cfg_data;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                w.func   = i_func;
                w.sample = i_counter_sample;
                w.a      = i_chan_a;
                w.b      = i_chan_b;
                w.c      = i_chan_c;
                pred = predict_levels(w);
                pending_levels.push_back(typed_on ? typed_lv : pred);
            end
            if (o_out_valid && !i_out_stall) begin
                got.lamp    = o_lamp_level;
                got.red     = o_red_level;
                got.green   = o_green_level;
                got.blue    = o_blue_level;
                got.wrapped = o_timer_wrapped;
                got.hue     = o_hue_now;
                if (pending_levels.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS) begin
                        $display("unexpected result word: lamp=%0d r=%0d g=%0d b=%0d w=%0d hue=%0d",
                                 got.lamp, got.red, got.green, got.blue, got.wrapped, got.hue);
                    end
                end else begin
                    want = pending_levels.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS) begin
                            $display("mismatch: exp lamp=%0d r=%0d g=%0d b=%0d w=%0d hue=%0d | got lamp=%0d r=%0d g=%0d b=%0d w=%0d hue=%0d",
                                     want.lamp, want.red, want.green, want.blue, want.wrapped,
                                     want.hue, got.lamp, got.red, got.green, got.blue,
                                     got.wrapped, got.hue);
                        end
                    end
                end
            end
        end
    end

    initial begin : p_stimulus
        row_t r;
        cfg_t c;
        int   k;
        int   n;
        int   ph;

        // reset defaults: lamps and RGB off
        add_checked(FN_TIMER, 8'd0, 8'd0, 8'd0, 8'd0, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0});
        add_checked(FN_SET_RGB, 8'd0, 8'd255, 8'd0, 8'd0,
                    '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0});
        add_config(2'd3, 2'd0, 8'd255, 8'd64);
        add_checked(FN_SET_RGB, 8'd0, 8'd255, 8'd255, 8'd255,
                    '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0});
        add_checked(FN_SET_RGB, 8'd0, 8'd0, 8'd0, 8'd0,
                    '{8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0});
        add_checked(FN_SET_RGB, 8'd0, 8'd0, 8'd255, 8'd0,
                    '{8'd255, 8'd0, 8'd255, 8'd0, 1'b0, 8'd86});
        add_checked(FN_SET_RGB, 8'd0, 8'd0, 8'd0, 8'd255,
                    '{8'd255, 8'd0, 8'd0, 8'd255, 1'b0, 8'd172});
        add_checked(FN_SET_RGB, 8'd0, 8'd255, 8'd0, 8'd255,
                    '{8'd255, 8'd255, 8'd0, 8'd255, 1'b0, 8'd213});
        add_word(FN_SET_RGB, 8'd0, 8'd10, 8'd200, 8'd100);
        add_checked(FN_SET_HSV, 8'd0, 8'd0, 8'd255, 8'd255,
                    '{8'd255, 8'd255, 8'd0, 8'd0, 1'b0, 8'd0});
        add_word(FN_SET_HSV, 8'd0, 8'd255, 8'd255, 8'd255);
        add_word(FN_SET_HSV, 8'd0, 8'd43, 8'd128, 8'd200);
        add_checked(FN_SET_HSV, 8'd0, 8'd100, 8'd0, 8'd77,
                    '{8'd255, 8'd77, 8'd77, 8'd77, 1'b0, 8'd100});
        add_checked(FN_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255,
                    '{8'd255, 8'd77, 8'd77, 8'd77, 1'b0, 8'd100});
        // hue cycling: four wraps step the hue once
        add_config(2'd3, 2'd2, 8'd200, 8'd64);
        for (k = 0; k < 4; k++) begin
            add_word(FN_TIMER, 8'd255, 8'd0, 8'd0, 8'd0);
            add_word(FN_TIMER, 8'd0, 8'd0, 8'd0, 8'd0);
        end
        add_config(2'd1, 2'd1, 8'd0, 8'd255);
        add_word(FN_SET_RGB, 8'd0, 8'd255, 8'd128, 8'd1);
        add_config(2'd2, 2'd3, 8'd0, 8'd0);
        add_word(FN_TIMER, 8'd0, 8'd0, 8'd0, 8'd0);
        add_config(2'd3, 2'd1, 8'd255, 8'd0);
        add_word(FN_SET_HSV, 8'd0, 8'd200, 8'd255, 8'd255);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_q[i]) begin
            r = plan_q[i];
            if (r.is_cfg) begin
                apply_config(r.c);
            end else begin
                offer_word(r.w, r.has_exp, r.e);
            end
        end

        for (k = 0; k < CHUNKS; k++) begin
            ph = k / (CHUNKS / 4);
            case (ph)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 75; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 75; end
                default: begin idle_pct = 19; stall_pct <= 19; end
            endcase
            if (k == 0) begin
                c = '{light: 2'd3, rgb: RGBM_CYCLE, lamp: 8'd255, dim: 8'd0};
            end else if (k == 1) begin
                c = '{light: 2'd3, rgb: RGBM_DIMMED, lamp: 8'd0, dim: 8'd255};
            end else begin
                c = random_config();
            end
            apply_config(c);
            if (k == 2) begin
                hold_req <= hold_req + 1;
            end
            for (n = 0; n < CHUNK_WORDS; n++) begin
                offer_word(random_word(), 1'b0, '0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/lce_pkg.sv
rtl/lce_muldiv.sv
rtl/led_color_engine_hsv.sv
test/led_color_engine_hsv_tb.sv
